/* rtl/dmss_pkg.sv */
// Shared types, constants and helpers for the drive mode safety supervisor.
`default_nettype none

package dmss_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

  typedef logic [TIMER_WIDTH-1:0] timer_t;
  typedef logic [CFG_W-1:0] cfg_word_t;
  typedef logic [CMP_W-1:0] cmp_t;

  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_IDLE   = 2'd1,
    MODE_MANUAL = 2'd2,
    MODE_AUTO   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_THROTTLE = 3'd1,
    CAUSE_BRAKE    = 3'd2,
    CAUSE_DMS      = 3'd3,
    CAUSE_HOST     = 3'd4,
    CAUSE_FAULT    = 3'd5,
    CAUSE_LINK     = 3'd6
  } cause_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOOT_WAIT   = 3'd0,
    CFG_BRAKE_CLEAR = 3'd1,
    CFG_DMS_HOLD    = 3'd2,
    CFG_DMS_GRACE   = 3'd3,
    CFG_AUTO_GRACE  = 3'd4
  } cfg_idx_t;

  localparam logic [1:0] HOST_MANUAL = 2'd2;

  localparam cfg_word_t BOOT_WAIT_RST   = 16'd2000;
  localparam cfg_word_t BRAKE_CLEAR_RST = 16'd1200;
  localparam cfg_word_t DMS_HOLD_RST    = 16'd1000;
  localparam cfg_word_t DMS_GRACE_RST   = 16'd2000;
  localparam cfg_word_t AUTO_GRACE_RST  = 16'd3000;

  typedef struct packed {
    cfg_word_t boot_wait_ms;
    cfg_word_t brake_retract_ms;
    cfg_word_t dms_hold_ms;
    cfg_word_t dms_release_grace_ms;
    cfg_word_t auto_entry_grace_ms;
  } cfg_t;

  typedef struct packed {
    logic       either_dms_held;
    logic       both_dms_active;
    logic       throttle_pressed;
    logic       brake_pressed;
    logic       fault_present;
    logic       heartbeat_ok;
    logic [1:0] host_mode;
  } in_item_t;

  typedef struct packed {
    mode_t  mode;
    logic   brake_engage;
    logic   idle_entry_pulse;
    logic   mode_changed;
    cause_t exit_cause;
  } out_item_t;

  typedef struct packed {
    mode_t  mode;
    logic   brake_cmd;
    timer_t uptime_count;
    logic   dms_seen;
    timer_t idle_elapsed;
    logic   hold_active;
    timer_t hold_elapsed;
    logic   release_active;
    timer_t release_elapsed;
    timer_t auto_elapsed;
  } state_t;

  function automatic timer_t sat_inc(timer_t v);
    return (v == {TIMER_WIDTH{1'b1}}) ? v : v + timer_t'(1);
  endfunction

  function automatic cmp_t tw(timer_t v);
    return cmp_t'(v);
  endfunction

  function automatic cmp_t cw(cfg_word_t v);
    return cmp_t'(v);
  endfunction

endpackage

`default_nettype wire

/* rtl/dmss_if.sv */
// Valid/ready channel interfaces for tick items and result items.
`default_nettype none

interface dmss_in_if import dmss_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dmss_out_if import dmss_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/dmss_cfg.sv */
// Configuration register file with reset defaults.
`default_nettype none

module dmss_cfg import dmss_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boot_wait_ms         <= BOOT_WAIT_RST;
      cfg.brake_retract_ms     <= BRAKE_CLEAR_RST;
      cfg.dms_hold_ms          <= DMS_HOLD_RST;
      cfg.dms_release_grace_ms <= DMS_GRACE_RST;
      cfg.auto_entry_grace_ms  <= AUTO_GRACE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BOOT_WAIT:   cfg.boot_wait_ms         <= cfg_wdata;
        CFG_BRAKE_CLEAR: cfg.brake_retract_ms     <= cfg_wdata;
        CFG_DMS_HOLD:    cfg.dms_hold_ms          <= cfg_wdata;
        CFG_DMS_GRACE:   cfg.dms_release_grace_ms <= cfg_wdata;
        CFG_AUTO_GRACE:  cfg.auto_entry_grace_ms  <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/dmss_core.sv */
// Per-tick mode logic: next supervisor state and the result item.
`default_nettype none

module dmss_core import dmss_pkg::*; (
  input  wire state_t   st,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output state_t        st_next,
  output out_item_t     res
);

  state_t s;
  cause_t cause;
  logic   pulse;
  logic   driver;
  logic   dms_go;

  always_comb begin
    s      = st;
    cause  = CAUSE_NONE;
    pulse  = 1'b0;
    driver = item.throttle_pressed | item.brake_pressed;
    dms_go = 1'b0;

    // advance the running counters before any decision
    s.uptime_count = sat_inc(st.uptime_count);
    if (st.mode == MODE_IDLE) s.idle_elapsed = sat_inc(st.idle_elapsed);
    if (st.hold_active) s.hold_elapsed = sat_inc(st.hold_elapsed);
    if (st.release_active) s.release_elapsed = sat_inc(st.release_elapsed);
    if (st.mode == MODE_AUTO) s.auto_elapsed = sat_inc(st.auto_elapsed);

    // fault or lost link past the entry grace forces manual first
    if (st.mode == MODE_AUTO &&
        tw(s.auto_elapsed) >= cw(cfg.auto_entry_grace_ms) &&
        (item.fault_present || !item.heartbeat_ok)) begin
      s.mode           = MODE_MANUAL;
      s.release_active = 1'b0;
      cause            = item.heartbeat_ok ? CAUSE_FAULT : CAUSE_LINK;
    end

    unique case (s.mode)
      MODE_INIT: begin
        if (item.either_dms_held) s.dms_seen = 1'b1;
        if (tw(s.uptime_count) > cw(cfg.boot_wait_ms) && s.dms_seen) begin
          s.mode     = MODE_IDLE;
          s.dms_seen = 1'b0;
        end
      end
      MODE_IDLE: begin
        if (tw(s.idle_elapsed) >= cw(cfg.brake_retract_ms)) begin
          if (driver) begin
            s.mode        = MODE_MANUAL;
            s.hold_active = 1'b0;
          end else begin
            dms_go = item.both_dms_active;
          end
        end
      end
      MODE_MANUAL: begin
        if (driver) s.hold_active = 1'b0;
        else dms_go = item.both_dms_active;
        if (!item.both_dms_active) s.hold_active = 1'b0;
      end
      MODE_AUTO: begin
        if (item.throttle_pressed) begin
          s.mode           = MODE_MANUAL;
          s.release_active = 1'b0;
          cause            = CAUSE_THROTTLE;
        end else if (item.brake_pressed) begin
          s.mode           = MODE_MANUAL;
          s.release_active = 1'b0;
          cause            = CAUSE_BRAKE;
        end else begin
          if (!item.both_dms_active) begin
            if (!s.release_active) begin
              s.release_active  = 1'b1;
              s.release_elapsed = '0;
            end
            if (tw(s.release_elapsed) > cw(cfg.dms_release_grace_ms)) begin
              s.mode           = MODE_MANUAL;
              s.release_active = 1'b0;
              cause            = CAUSE_DMS;
            end
          end else begin
            s.release_active = 1'b0;
          end
          if (s.mode == MODE_AUTO && item.host_mode == HOST_MANUAL) begin
            s.mode           = MODE_MANUAL;
            s.release_active = 1'b0;
            cause            = CAUSE_HOST;
          end
        end
      end
    endcase

    // dead-man hold without driver input: start or keep the hold, then enter
    if (dms_go) begin
      if (!s.hold_active) begin
        s.hold_active  = 1'b1;
        s.hold_elapsed = '0;
      end
      if (tw(s.hold_elapsed) >= cw(cfg.dms_hold_ms)) begin
        s.mode           = MODE_AUTO;
        s.hold_active    = 1'b0;
        s.release_active = 1'b0;
        s.auto_elapsed   = '0;
      end
    end else if (s.mode == MODE_IDLE && st.mode == MODE_IDLE &&
                 tw(s.idle_elapsed) >= cw(cfg.brake_retract_ms)) begin
      s.hold_active = 1'b0;
    end

    if (s.mode == MODE_AUTO) cause = CAUSE_NONE;

    if (s.mode != st.mode) begin
      if (s.mode == MODE_IDLE) begin
        s.idle_elapsed = '0;
        s.brake_cmd    = 1'b0;
        pulse          = 1'b1;
      end else if (s.mode == MODE_INIT) begin
        s.brake_cmd = 1'b1;
      end
    end

    st_next              = s;
    res.mode             = s.mode;
    res.brake_engage     = s.brake_cmd;
    res.idle_entry_pulse = pulse;
    res.mode_changed     = (s.mode != st.mode);
    res.exit_cause       = cause;
  end

endmodule

`default_nettype wire

/* rtl/drive_mode_safety_supervisor_top.sv */
// Top level: supervisor state, configuration and the result output register.
//
//   channel   dir   handshake        payload
//   in_ch     in    valid/ready      in_item_t, one per millisecond tick
//   out_ch    out   valid/ready      out_item_t, one per tick item
//   cfg_*     in    cfg_we           cfg_index (3b), cfg_wdata (16b)
//
// One tick item per clock while in_ch.ready is high: state and result registers are
// updated in the cycle the item is accepted; the result shows in the next cycle.
// in_ch.ready is high while the result register is empty or being drained.
// rst (synchronous) restores the register defaults and the init mode with
// the brakes engaged.
`default_nettype none

module drive_mode_safety_supervisor_top import dmss_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  dmss_in_if.sink                   in_ch,
  dmss_out_if.source                out_ch
);

  cfg_t      cfg;
  state_t    st;
  state_t    st_next;
  out_item_t res;
  out_item_t out_data;
  logic      out_valid;
  logic      accept;

  dmss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dmss_core u_core (
    .st      (st),
    .item    (in_ch.data),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (res)
  );

  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode            <= MODE_INIT;
      st.brake_cmd       <= 1'b1;
      st.uptime_count    <= '0;
      st.dms_seen        <= 1'b0;
      st.idle_elapsed    <= '0;
      st.hold_active     <= 1'b0;
      st.hold_elapsed    <= '0;
      st.release_active  <= 1'b0;
      st.release_elapsed <= '0;
      st.auto_elapsed    <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data <= res;
  end

`ifndef SYNTH
  a_cause_means_manual: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.exit_cause != CAUSE_NONE |-> out_data.mode == MODE_MANUAL)
    else $error("exit cause reported without landing in manual");

  a_idle_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.idle_entry_pulse |->
      out_data.mode == MODE_IDLE && out_data.mode_changed && !out_data.brake_engage)
    else $error("idle entry pulse inconsistent with result");

  a_init_brakes: assert property (@(posedge clk) disable iff (rst)
    st.mode == MODE_INIT |-> st.brake_cmd)
    else $error("brakes released while in init");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid && out_data.mode == st.mode)
    else $error("accepted item produced no matching result");
`endif

endmodule

`default_nettype wire

/* tb/dmss_mode_checker.sv */
// Watches the tick and result channels, predicts each result and compares it.
module dmss_mode_checker import dmss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  dmss_in_if                   in_ch,
  dmss_out_if                  out_ch,
  output int                   fail_count,
  output int                   pending_items
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t      regs;
  state_t    sup;
  out_item_t results_due[$];

  function automatic timer_t timer_bump(input timer_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Dead-man hold without driver input arms autonomous once the hold time is met.
  function automatic void dead_man_hold(input logic held, input logic driver);
    if (held && !driver) begin
      if (!sup.hold_active) begin
        sup.hold_active  = 1'b1;
        sup.hold_elapsed = '0;
      end
      if (sup.hold_elapsed >= regs.dms_hold_ms) begin
        sup.mode           = MODE_AUTO;
        sup.hold_active    = 1'b0;
        sup.release_active = 1'b0;
        sup.auto_elapsed   = '0;
      end
    end else begin
      sup.hold_active = 1'b0;
    end
  endfunction

  function automatic void leave_auto(input cause_t why, inout cause_t cause);
    sup.mode           = MODE_MANUAL;
    sup.release_active = 1'b0;
    cause              = why;
  endfunction

  function automatic out_item_t supervise_tick(input in_item_t t);
    mode_t     prev;
    cause_t    cause;
    logic      pulse;
    out_item_t r;
    prev  = sup.mode;
    cause = CAUSE_NONE;
    pulse = 1'b0;

    // Advance the running counters before the mode logic looks at them.
    sup.uptime_count = timer_bump(sup.uptime_count);
    if (sup.mode == MODE_IDLE) sup.idle_elapsed = timer_bump(sup.idle_elapsed);
    if (sup.hold_active) sup.hold_elapsed = timer_bump(sup.hold_elapsed);
    if (sup.release_active) sup.release_elapsed = timer_bump(sup.release_elapsed);
    if (sup.mode == MODE_AUTO) sup.auto_elapsed = timer_bump(sup.auto_elapsed);

    if (sup.mode == MODE_AUTO && sup.auto_elapsed >= regs.auto_entry_grace_ms &&
        (t.fault_present || !t.heartbeat_ok)) begin
      leave_auto(t.heartbeat_ok ? CAUSE_FAULT : CAUSE_LINK, cause);
    end

    case (sup.mode)
      MODE_INIT: begin
        if (t.either_dms_held) sup.dms_seen = 1'b1;
        if (sup.uptime_count > regs.boot_wait_ms && sup.dms_seen) begin
          sup.mode     = MODE_IDLE;
          sup.dms_seen = 1'b0;
        end
      end
      MODE_IDLE: begin
        // Hold off everything until the brakes have retracted.
        if (sup.idle_elapsed >= regs.brake_retract_ms) begin
          if (t.throttle_pressed || t.brake_pressed) begin
            sup.mode        = MODE_MANUAL;
            sup.hold_active = 1'b0;
          end else begin
            dead_man_hold(t.both_dms_active, 1'b0);
          end
        end
      end
      MODE_MANUAL: begin
        dead_man_hold(t.both_dms_active, t.throttle_pressed || t.brake_pressed);
      end
      default: begin
        if (t.throttle_pressed) begin
          leave_auto(CAUSE_THROTTLE, cause);
        end else if (t.brake_pressed) begin
          leave_auto(CAUSE_BRAKE, cause);
        end else begin
          if (!t.both_dms_active) begin
            if (!sup.release_active) begin
              sup.release_active  = 1'b1;
              sup.release_elapsed = '0;
            end
            if (sup.release_elapsed > regs.dms_release_grace_ms) leave_auto(CAUSE_DMS, cause);
          end else begin
            sup.release_active = 1'b0;
          end
          if (sup.mode == MODE_AUTO && t.host_mode == HOST_MANUAL) leave_auto(CAUSE_HOST, cause);
        end
      end
    endcase

    if (sup.mode == MODE_AUTO) cause = CAUSE_NONE;

    if (sup.mode != prev) begin
      if (sup.mode == MODE_IDLE) begin
        sup.idle_elapsed = '0;
        sup.brake_cmd    = 1'b0;
        pulse            = 1'b1;
      end else if (sup.mode == MODE_INIT) begin
        sup.brake_cmd = 1'b1;
      end
    end

    r.mode             = sup.mode;
    r.brake_engage     = sup.brake_cmd;
    r.idle_entry_pulse = pulse;
    r.mode_changed     = (sup.mode != prev);
    r.exit_cause       = cause;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [2:0] want,
                                      input logic [2:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst) begin
      regs = '{BOOT_WAIT_RST, BRAKE_CLEAR_RST, DMS_HOLD_RST, DMS_GRACE_RST, AUTO_GRACE_RST};
      sup           = '0;
      sup.mode      = MODE_INIT;
      sup.brake_cmd = 1'b1;
      results_due.delete();
      fail_count    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BOOT_WAIT:   regs.boot_wait_ms         = cfg_wdata;
          CFG_BRAKE_CLEAR: regs.brake_retract_ms     = cfg_wdata;
          CFG_DMS_HOLD:    regs.dms_hold_ms          = cfg_wdata;
          CFG_DMS_GRACE:   regs.dms_release_grace_ms = cfg_wdata;
          CFG_AUTO_GRACE:  regs.auto_entry_grace_ms  = cfg_wdata;
          default: ;
        endcase
      end
      // Retire the result first: it belongs to an earlier tick.
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (results_due.size() == 0) begin
          $error("result item with nothing expected: mode %0d cause %0d",
                 got.mode, got.exit_cause);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("mode", 3'(want.mode), 3'(got.mode));
          check_field("brake_engage", 3'(want.brake_engage), 3'(got.brake_engage));
          check_field("idle_entry_pulse", 3'(want.idle_entry_pulse),
                      3'(got.idle_entry_pulse));
          check_field("mode_changed", 3'(want.mode_changed), 3'(got.mode_changed));
          check_field("exit_cause", want.exit_cause, got.exit_cause);
        end
      end
      if (in_ch.valid && in_ch.ready) results_due.push_back(supervise_tick(in_ch.data));
    end
    pending_items = results_due.size();
  end

endmodule

/* tb/drive_mode_safety_supervisor_top_tb.sv */
// Stimulus, idling control and verdict for the drive mode supervisor.
module drive_mode_safety_supervisor_top_tb import dmss_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int TICKS_PER_PHASE = 195;
  localparam logic [1:0] HOST_NONE = 2'd0;

  typedef enum int {SEG_HOLD, SEG_DRIVER, SEG_RELEASE, SEG_TROUBLE, SEG_HOST, SEG_NOISE}
    seg_kind_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   fail_count;
  int                   pending_items;
  int                   send_gap_pct = 0;
  int                   recv_stall_pct = 0;
  int                   quiet_cycles = 0;

  dmss_in_if  in_ch ();
  dmss_out_if out_ch ();

  always #4 clk = ~clk;

  drive_mode_safety_supervisor_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  dmss_mode_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_items (pending_items)
  );

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic in_item_t tick_of(input logic e, input logic b, input logic thr,
                                       input logic brk, input logic f, input logic hb,
                                       input logic [1:0] host);
    return '{e, b, thr, brk, f, hb, host};
  endfunction

  // Mostly plausible driving with random content; a few ticks are pure noise.
  function automatic in_item_t shape_tick(input seg_kind_t kind);
    in_item_t t;
    t = in_item_t'($urandom);
    if (kind == SEG_NOISE || $urandom_range(0, 19) == 0) return t;
    t.either_dms_held  = 1'b1;
    t.both_dms_active  = 1'b1;
    t.throttle_pressed = 1'b0;
    t.brake_pressed    = 1'b0;
    t.fault_present    = 1'b0;
    t.heartbeat_ok     = 1'b1;
    if (t.host_mode == HOST_MANUAL) t.host_mode ^= 2'b01;
    case (kind)
      SEG_DRIVER: begin
        t.throttle_pressed = 1'($urandom_range(0, 1));
        t.brake_pressed    = !t.throttle_pressed || ($urandom_range(0, 1) == 1);
        t.both_dms_active  = 1'($urandom_range(0, 1));
      end
      SEG_RELEASE: begin
        t.both_dms_active = 1'b0;
        t.either_dms_held = 1'($urandom_range(0, 1));
      end
      SEG_TROUBLE: begin
        t.fault_present = 1'($urandom_range(0, 1));
        t.heartbeat_ok  = t.fault_present && ($urandom_range(0, 1) == 1);
      end
      SEG_HOST: t.host_mode = HOST_MANUAL;
      default: ;
    endcase
    return t;
  endfunction

  function automatic cfg_t phase_regs(input int p);
    cfg_t c;
    c.boot_wait_ms         = CFG_W'($urandom_range(0, 40));
    c.brake_retract_ms     = CFG_W'($urandom_range(0, 40));
    c.dms_hold_ms          = CFG_W'($urandom_range(0, 12));
    c.dms_release_grace_ms = CFG_W'($urandom_range(0, 12));
    c.auto_entry_grace_ms  = CFG_W'($urandom_range(0, 12));
    case (p)
      1: c.dms_hold_ms = '1;
      3: begin
        c.dms_release_grace_ms = '1;
        c.auto_entry_grace_ms  = '1;
      end
      4: c = '0;
      default: ;
    endcase
    return c;
  endfunction

  task automatic send_tick(input in_item_t t);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_items != 0) @(negedge clk);
  endtask

  // Write all five registers, then one random out-of-range index that must be ignored.
  task automatic program_regs(input cfg_t c);
    for (int i = 0; i <= int'(CFG_AUTO_GRACE) + 1; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      if (i > int'(CFG_AUTO_GRACE)) begin
        cfg_index <= CFG_IDX_W'($urandom_range(int'(CFG_AUTO_GRACE) + 1,
                                               (1 << CFG_IDX_W) - 1));
      end else begin
        cfg_index <= CFG_IDX_W'(i);
      end
      case (i)
        CFG_BOOT_WAIT:   cfg_wdata <= c.boot_wait_ms;
        CFG_BRAKE_CLEAR: cfg_wdata <= c.brake_retract_ms;
        CFG_DMS_HOLD:    cfg_wdata <= c.dms_hold_ms;
        CFG_DMS_GRACE:   cfg_wdata <= c.dms_release_grace_ms;
        CFG_AUTO_GRACE:  cfg_wdata <= c.auto_entry_grace_ms;
        default:         cfg_wdata <= CFG_W'($urandom);
      endcase
      @(posedge clk);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int        sent;
    int        seg_len;
    int        roll;
    seg_kind_t kind;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Register defaults: a dead-man press during boot is latched but init holds.
    send_tick('0);
    send_tick(in_item_t'('1));
    drain();
    program_regs('{16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0});
    send_tick(tick_of(1, 0, 0, 0, 0, 1, HOST_NONE));
    send_tick(tick_of(1, 1, 0, 0, 0, 1, HOST_NONE));
    drain();
    // Zero boot wait: the latched dead-man press moves to idle at once.
    program_regs('{16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0});
    send_tick('0);
    // Brakes still retracting: driver and dead-man input are ignored.
    send_tick(tick_of(0, 0, 1, 0, 0, 1, HOST_NONE));
    send_tick(tick_of(0, 0, 0, 1, 0, 1, HOST_NONE));
    send_tick(tick_of(1, 1, 0, 0, 0, 1, HOST_NONE));
    drain();
    program_regs('{16'd0, 16'd4, 16'd0, 16'd0, 16'd0});
    send_tick(tick_of(1, 1, 0, 0, 0, 1, HOST_NONE));
    // Fault with dead-man held: forced out and straight back in.
    send_tick(tick_of(1, 1, 0, 0, 1, 1, HOST_NONE));
    send_tick(tick_of(0, 0, 0, 0, 1, 1, HOST_NONE));
    send_tick(tick_of(1, 1, 0, 0, 0, 1, HOST_NONE));
    // Fault and lost link together.
    send_tick(tick_of(0, 0, 0, 0, 1, 0, HOST_NONE));
    send_tick(tick_of(1, 1, 0, 0, 0, 1, HOST_NONE));
    send_tick(tick_of(1, 1, 1, 0, 0, 1, HOST_NONE));
    send_tick(tick_of(1, 1, 0, 0, 0, 1, HOST_NONE));
    send_tick(tick_of(1, 1, 0, 1, 0, 1, HOST_NONE));
    send_tick(tick_of(1, 1, 0, 0, 0, 1, HOST_NONE));
    send_tick(tick_of(1, 1, 0, 0, 0, 1, HOST_MANUAL));
    send_tick(tick_of(1, 1, 0, 0, 0, 1, HOST_NONE));
    send_tick(tick_of(0, 0, 0, 0, 0, 1, HOST_NONE));
    send_tick(tick_of(0, 0, 0, 0, 0, 1, HOST_NONE));
    send_tick(tick_of(1, 1, 1, 0, 0, 1, HOST_NONE));
    send_tick(tick_of(1, 1, 0, 0, 0, 1, HOST_NONE));
    drain();
    // Entry grace: faults inside the window are ignored.
    program_regs('{16'd0, 16'd4, 16'd0, 16'd0, 16'd2});
    send_tick(tick_of(1, 1, 0, 0, 1, 1, HOST_NONE));
    send_tick(tick_of(1, 1, 0, 0, 1, 1, HOST_NONE));
    send_tick(tick_of(1, 1, 0, 0, 0, 0, HOST_NONE));

    for (int s = 0; s < 3; s++) begin
      send_gap_pct   = (s == 0) ? 30 : (s == 1) ? 77 : 0;
      recv_stall_pct = (s == 0) ? 77 : (s == 1) ? 30 : 0;
      for (int k = 0; k < 2; k++) begin
        drain();
        program_regs(phase_regs(2 * s + k));
        sent = 0;
        while (sent < TICKS_PER_PHASE) begin
          roll = $urandom_range(0, 99);
          kind = (roll < 45) ? SEG_HOLD :
                 (roll < 60) ? SEG_DRIVER :
                 (roll < 75) ? SEG_RELEASE :
                 (roll < 85) ? SEG_TROUBLE :
                 (roll < 90) ? SEG_HOST : SEG_NOISE;
          seg_len = $urandom_range(1, 24);
          repeat (seg_len) begin
            send_tick(shape_tick(kind));
            sent++;
          end
        end
      end
    end

    drain();
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
